[hdl/agwa_pkg.sv]
// Shared types, codes and cost helpers for the affine-gap walk alignment core.
package agwa_pkg;

	localparam int MAX_LEN = 32;
	localparam int COST_W = 16;
	localparam int IDX_W = $clog2(MAX_LEN);
	localparam int LEN_W = $clog2(MAX_LEN + 1);
	localparam int WIDE_W = COST_W + 16;
	localparam int OPS_DEPTH = 2 * MAX_LEN;
	localparam int OPS_AW = $clog2(OPS_DEPTH);
	localparam int OPS_CW = $clog2(OPS_DEPTH + 1);

	typedef logic [COST_W-1:0] cost_t;
	typedef logic [32:0] step_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [WIDE_W-1:0] wide_t;

	localparam cost_t INF = '1;

	// Request kinds
	localparam logic [1:0] REQ_FIRST = 2'd0;
	localparam logic [1:0] REQ_SECOND = 2'd1;
	localparam logic [1:0] REQ_RUN = 2'd2;

	// Edit operations
	localparam logic [2:0] OP_MATCH = 3'd0;
	localparam logic [2:0] OP_MISMATCH = 3'd1;
	localparam logic [2:0] OP_INS = 3'd2;
	localparam logic [2:0] OP_DEL = 3'd3;
	localparam logic [2:0] OP_NONE = 3'd4;

	// Status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_TB_FAIL = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_MATCH = 2'd0;
	localparam logic [1:0] REG_MISMATCH = 2'd1;
	localparam logic [1:0] REG_GAP_OPEN = 2'd2;
	localparam logic [1:0] REG_GAP_EXT = 2'd3;

	typedef struct packed {
		logic [7:0] match_cost;
		logic [7:0] mismatch_cost;
		logic [7:0] gap_open_cost;
		logic [7:0] gap_extend_cost;
	} costs_t;

	// Data handed from one cell to the next: one row of the wavefront
	typedef struct packed {
		logic valid;
		logic first;
		idx_t row;
		step_t a;
		cost_t m;
		cost_t d;
		cost_t mdiag;
	} link_t;

	// Saturating add; anything at or past INF becomes INF
	function automatic cost_t sadd(cost_t a, wide_t b);
		logic [WIDE_W:0] s;
		s = (WIDE_W + 1)'(a) + (WIDE_W + 1)'(b);
		return (s >= (WIDE_W + 1)'(INF)) ? INF : cost_t'(s);
	endfunction

	function automatic cost_t min2(cost_t a, cost_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic cost_t min3(cost_t a, cost_t b, cost_t c);
		return min2(a, min2(b, c));
	endfunction

	// Gap cost of length n: n * extend + open, saturated
	function automatic cost_t gap_cost(len_t n, logic [7:0] ext, logic [7:0] opn);
		wide_t p;
		p = WIDE_W'(n) * WIDE_W'(ext);
		return sadd(cost_t'(opn), p);
	endfunction

	// Matrix entry with the fixed top row and left column folded in
	function automatic cost_t mget(len_t r, len_t c, cost_t raw);
		if (r == '0 && c == '0) begin
			return '0;
		end else if (r == '0 || c == '0) begin
			return INF;
		end
		return raw;
	endfunction

endpackage

[hdl/agwa_cell.sv]
// One column cell of the alignment array: holds a second-sequence step and its M column.
module agwa_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  agwa_pkg::costs_t    costs,
	input  agwa_pkg::len_t      col,
	input  logic                b_wr,
	input  agwa_pkg::step_t     b_data,
	input  agwa_pkg::link_t     link_in,
	output agwa_pkg::link_t     link_out,
	input  agwa_pkg::idx_t      rd_row,
	output agwa_pkg::cost_t     rd_data,
	output agwa_pkg::step_t     b_step
);

	agwa_pkg::step_t b_q;
	agwa_pkg::cost_t mup_q;
	agwa_pkg::cost_t iup_q;
	agwa_pkg::link_t out_q;
	agwa_pkg::cost_t rd_q;
	agwa_pkg::cost_t mcol [agwa_pkg::MAX_LEN];

	agwa_pkg::wide_t oe;
	agwa_pkg::cost_t step_cost;
	agwa_pkg::cost_t mup;
	agwa_pkg::cost_t iup;
	agwa_pkg::cost_t iv;
	agwa_pkg::cost_t dv;
	agwa_pkg::cost_t mv;

	// Compute M, I and D for the row passing through this column
	always_comb begin
		oe = agwa_pkg::WIDE_W'(costs.gap_open_cost) + agwa_pkg::WIDE_W'(costs.gap_extend_cost);
		step_cost = (link_in.a == b_q) ? agwa_pkg::COST_W'(costs.match_cost)
			: agwa_pkg::COST_W'(costs.mismatch_cost);
		mup = link_in.first ? agwa_pkg::INF : mup_q;
		iup = link_in.first ? agwa_pkg::gap_cost(col, costs.gap_extend_cost, costs.gap_open_cost)
			: iup_q;
		iv = agwa_pkg::min2(agwa_pkg::sadd(mup, oe),
			agwa_pkg::sadd(iup, agwa_pkg::WIDE_W'(costs.gap_extend_cost)));
		dv = agwa_pkg::min2(agwa_pkg::sadd(link_in.m, oe),
			agwa_pkg::sadd(link_in.d, agwa_pkg::WIDE_W'(costs.gap_extend_cost)));
		mv = agwa_pkg::min3(agwa_pkg::sadd(link_in.mdiag, agwa_pkg::WIDE_W'(step_cost)), iv, dv);
	end

	// Hold the step and the column state, pass the row to the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else begin
			out_q.valid <= link_in.valid;
			out_q.first <= link_in.first;
			out_q.row <= link_in.row;
			out_q.a <= link_in.a;
			out_q.m <= mv;
			out_q.d <= dv;
			out_q.mdiag <= mup;
		end
	end

	always_ff @(posedge clk) begin
		if (b_wr) begin
			b_q <= b_data;
		end
		if (link_in.valid) begin
			mup_q <= mv;
			iup_q <= iv;
			mcol[link_in.row] <= mv;
		end
		rd_q <= mcol[rd_row];
	end

	assign link_out = out_q;
	assign rd_data = rd_q;
	assign b_step = b_q;

endmodule

[hdl/affine_gap_walk_alignment_core.sv]
// Top level of the affine-gap walk alignment core: loads, cell array, traceback, output.
//
// Input stream s_*: s_tuser carries the request kind (append to first sequence,
// append to second sequence, run). Appends give no result.
// A run fills the cost matrices through a row of 32 cells, one per column of the
// second sequence; rows of the first sequence walk through the cells as an
// anti-diagonal wavefront. Traceback then passes TB_CHK, TB_HERE, TB_UP and TB_DEC
// per diagonal or gap step and TB_CHK alone per tail gap step, reading the
// per-cell column memories, and the transcript leaves first to last on m_*,
// each result through EM_RD and then EM_OUT.
// The input is not accepted while a run is in progress; the run clears both
// sequences and the overflow flag when it is accepted.
// Results hold on m_* while m_tready is low. cfg_* writes the cost registers;
// cfg_ready is always high. Reset returns the costs to their defaults, empties
// both sequences and drops any run in progress.
module affine_gap_walk_alignment_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_addr,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] vertex_id, [32] orientation, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [2:0] edit_op, [18:3] align_score, rest zero
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast    // last_op
);

	typedef enum logic [3:0] {
		IDLE, FILL, SC_RD, SC_CAP, TB_CHK, TB_HERE, TB_UP, TB_DEC, EM_RD, EM_OUT, OUT_ONE
	} state_t;

	localparam int CNT_W = $clog2(2 * agwa_pkg::MAX_LEN + 4);

	state_t state_q;
	agwa_pkg::costs_t costs_q;
	agwa_pkg::len_t len1_q, len2_q, n_q, m_q, ti_q, tj_q;
	logic ovf_q;
	logic [CNT_W-1:0] cnt_q;
	agwa_pkg::link_t feed_q;
	agwa_pkg::step_t first_seq [agwa_pkg::MAX_LEN];
	agwa_pkg::cost_t here_q, left_q, score_q;
	logic [2:0] one_op_q;
	logic [1:0] status_q;
	logic [agwa_pkg::OPS_CW-1:0] op_cnt_q;
	logic [agwa_pkg::OPS_AW-1:0] ptr_q;
	logic [2:0] ops_mem [agwa_pkg::OPS_DEPTH];
	logic [2:0] ops_rd_q;

	agwa_pkg::link_t links [agwa_pkg::MAX_LEN + 1];
	agwa_pkg::cost_t rdata [agwa_pkg::MAX_LEN];
	agwa_pkg::step_t bsteps [agwa_pkg::MAX_LEN];

	logic in_acc, out_acc;
	agwa_pkg::step_t in_step;
	agwa_pkg::idx_t rd_row, seq_idx, jm1, jm2;
	agwa_pkg::step_t a_step;
	logic eq;
	agwa_pkg::cost_t up, diag, diagc, raw_j1, raw_j2;
	logic push;
	logic [2:0] push_op;

	assign in_acc = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign in_step = {s_tdata[31:0], s_tdata[32]};
	assign s_tready = (state_q == IDLE);
	assign cfg_ready = 1'b1;

	// Cell array: each cell owns one column
	assign links[0] = feed_q;
	for (genvar c = 0; c < agwa_pkg::MAX_LEN; c++) begin : g_cell
		agwa_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.costs    (costs_q),
			.col      (agwa_pkg::LEN_W'(c + 1)),
			.b_wr     (in_acc && s_tuser == agwa_pkg::REQ_SECOND
				&& len2_q == agwa_pkg::LEN_W'(c)),
			.b_data   (in_step),
			.link_in  (links[c]),
			.link_out (links[c + 1]),
			.rd_row   (rd_row),
			.rd_data  (rdata[c]),
			.b_step   (bsteps[c])
		);
	end

	// Column memory row address for each phase
	always_comb begin
		case (state_q)
			SC_RD: rd_row = agwa_pkg::IDX_W'(n_q - 1'b1);
			TB_UP: rd_row = agwa_pkg::IDX_W'(ti_q - 2'd2);
			default: rd_row = agwa_pkg::IDX_W'(ti_q - 1'b1);
		endcase
	end

	// Traceback neighborhood
	always_comb begin
		seq_idx = (state_q == FILL) ? agwa_pkg::IDX_W'(cnt_q) : agwa_pkg::IDX_W'(ti_q - 1'b1);
		a_step = first_seq[seq_idx];
		jm1 = agwa_pkg::IDX_W'(tj_q - 1'b1);
		jm2 = agwa_pkg::IDX_W'(tj_q - 2'd2);
		raw_j1 = rdata[jm1];
		raw_j2 = rdata[jm2];
		eq = (a_step == bsteps[jm1]);
		up = agwa_pkg::mget(ti_q - 1'b1, tj_q, raw_j1);
		diag = agwa_pkg::mget(ti_q - 1'b1, tj_q - 1'b1, raw_j2);
		diagc = agwa_pkg::sadd(diag, eq ? agwa_pkg::WIDE_W'(costs_q.match_cost)
			: agwa_pkg::WIDE_W'(costs_q.mismatch_cost));
	end

	// Pick the operation that goes onto the transcript stack
	always_comb begin
		push = 1'b0;
		push_op = agwa_pkg::OP_NONE;
		case (state_q)
			TB_CHK: begin
				if (ti_q != '0 && tj_q == '0) begin
					push = 1'b1;
					push_op = agwa_pkg::OP_INS;
				end else if (ti_q == '0 && tj_q != '0) begin
					push = 1'b1;
					push_op = agwa_pkg::OP_DEL;
				end
			end
			TB_DEC: begin
				if (here_q == agwa_pkg::min3(up, left_q, diagc)) begin
					push = 1'b1;
					push_op = eq ? agwa_pkg::OP_MATCH : agwa_pkg::OP_MISMATCH;
				end else if (up == agwa_pkg::min3(up, left_q, here_q)) begin
					push = 1'b1;
					push_op = agwa_pkg::OP_INS;
				end else if (left_q == agwa_pkg::min3(up, left_q, here_q)) begin
					push = 1'b1;
					push_op = agwa_pkg::OP_DEL;
				end
			end
			default: ;
		endcase
	end

	// Transcript stack and first-sequence store
	always_ff @(posedge clk) begin
		if (push) begin
			ops_mem[agwa_pkg::OPS_AW'(op_cnt_q)] <= push_op;
		end
		ops_rd_q <= ops_mem[ptr_q];
		if (in_acc && s_tuser == agwa_pkg::REQ_FIRST && len1_q < agwa_pkg::LEN_W'(agwa_pkg::MAX_LEN)) begin
			first_seq[agwa_pkg::IDX_W'(len1_q)] <= in_step;
		end
	end

	// Cost registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			costs_q <= '{8'd0, 8'd1, 8'd4, 8'd1};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				agwa_pkg::REG_MATCH: costs_q.match_cost <= cfg_data;
				agwa_pkg::REG_MISMATCH: costs_q.mismatch_cost <= cfg_data;
				agwa_pkg::REG_GAP_OPEN: costs_q.gap_open_cost <= cfg_data;
				agwa_pkg::REG_GAP_EXT: costs_q.gap_extend_cost <= cfg_data;
				default: ;
			endcase
		end
	end

	// Feed rows of the first sequence into the cell array
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_q <= '0;
		end else begin
			feed_q.valid <= (state_q == FILL) && (CNT_W'(n_q) > cnt_q);
			feed_q.first <= (cnt_q == '0);
			feed_q.row <= agwa_pkg::IDX_W'(cnt_q);
			feed_q.a <= a_step;
			feed_q.m <= agwa_pkg::INF;
			feed_q.d <= agwa_pkg::gap_cost(agwa_pkg::LEN_W'(cnt_q + 1'b1),
				costs_q.gap_extend_cost, costs_q.gap_open_cost);
			feed_q.mdiag <= (cnt_q == '0) ? '0 : agwa_pkg::INF;
		end
	end

	// Sequencer: loads, fill, traceback, emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			len1_q <= '0;
			len2_q <= '0;
			ovf_q <= 1'b0;
			n_q <= '0;
			m_q <= '0;
			ti_q <= '0;
			tj_q <= '0;
			cnt_q <= '0;
			op_cnt_q <= '0;
			ptr_q <= '0;
			here_q <= '0;
			left_q <= '0;
			score_q <= '0;
			one_op_q <= agwa_pkg::OP_NONE;
			status_q <= agwa_pkg::ST_OK;
		end else begin
			if (push) begin
				op_cnt_q <= op_cnt_q + 1'b1;
			end
			case (state_q)
				IDLE: begin
					if (in_acc) begin
						case (s_tuser)
							agwa_pkg::REQ_FIRST: begin
								if (len1_q >= agwa_pkg::LEN_W'(agwa_pkg::MAX_LEN)) begin
									ovf_q <= 1'b1;
								end else begin
									len1_q <= len1_q + 1'b1;
								end
							end
							agwa_pkg::REQ_SECOND: begin
								if (len2_q >= agwa_pkg::LEN_W'(agwa_pkg::MAX_LEN)) begin
									ovf_q <= 1'b1;
								end else begin
									len2_q <= len2_q + 1'b1;
								end
							end
							agwa_pkg::REQ_RUN: begin
								n_q <= len1_q;
								m_q <= len2_q;
								ti_q <= len1_q;
								tj_q <= len2_q;
								len1_q <= '0;
								len2_q <= '0;
								ovf_q <= 1'b0;
								cnt_q <= '0;
								op_cnt_q <= '0;
								if (ovf_q) begin
									one_op_q <= agwa_pkg::OP_NONE;
									score_q <= agwa_pkg::INF;
									status_q <= agwa_pkg::ST_OVERFLOW;
									state_q <= OUT_ONE;
								end else begin
									state_q <= FILL;
								end
							end
							default: ;
						endcase
					end
				end
				FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(n_q) + CNT_W'(agwa_pkg::MAX_LEN + 2)) begin
						state_q <= SC_RD;
					end
				end
				SC_RD: state_q <= SC_CAP;
				SC_CAP: begin
					score_q <= agwa_pkg::mget(n_q, m_q, raw_j1);
					status_q <= agwa_pkg::ST_OK;
					if (n_q == agwa_pkg::LEN_W'(1) && m_q == agwa_pkg::LEN_W'(1)) begin
						one_op_q <= eq ? agwa_pkg::OP_MATCH : agwa_pkg::OP_MISMATCH;
						state_q <= OUT_ONE;
					end else begin
						state_q <= TB_CHK;
					end
				end
				TB_CHK: begin
					if (ti_q != '0 && tj_q != '0) begin
						state_q <= TB_HERE;
					end else if (ti_q != '0) begin
						ti_q <= ti_q - 1'b1;
					end else if (tj_q != '0) begin
						tj_q <= tj_q - 1'b1;
					end else if (op_cnt_q == '0) begin
						one_op_q <= agwa_pkg::OP_NONE;
						state_q <= OUT_ONE;
					end else begin
						ptr_q <= agwa_pkg::OPS_AW'(op_cnt_q - 1'b1);
						state_q <= EM_RD;
					end
				end
				TB_HERE: state_q <= TB_UP;
				TB_UP: begin
					here_q <= raw_j1;
					left_q <= agwa_pkg::mget(ti_q, tj_q - 1'b1, raw_j2);
					state_q <= TB_DEC;
				end
				TB_DEC: begin
					if (!push) begin
						one_op_q <= agwa_pkg::OP_NONE;
						status_q <= agwa_pkg::ST_TB_FAIL;
						state_q <= OUT_ONE;
					end else begin
						if (push_op != agwa_pkg::OP_DEL) begin
							ti_q <= ti_q - 1'b1;
						end
						if (push_op != agwa_pkg::OP_INS) begin
							tj_q <= tj_q - 1'b1;
						end
						state_q <= TB_CHK;
					end
				end
				EM_RD: state_q <= EM_OUT;
				EM_OUT: begin
					if (m_tready) begin
						if (ptr_q == '0) begin
							state_q <= IDLE;
						end else begin
							ptr_q <= ptr_q - 1'b1;
							state_q <= EM_RD;
						end
					end
				end
				OUT_ONE: begin
					if (m_tready) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// Result channel
	assign m_tvalid = (state_q == EM_OUT) || (state_q == OUT_ONE);
	assign m_tlast = (state_q == OUT_ONE) || (ptr_q == '0);
	assign m_tdata = {5'd0, 16'(score_q), (state_q == EM_OUT) ? ops_rd_q : one_op_q};
	assign m_tuser = status_q;

`ifndef NO_ASSERTIONS
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a result is pending");
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		op_cnt_q <= agwa_pkg::OPS_CW'(agwa_pkg::OPS_DEPTH))
		else $error("transcript stack overrun");
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tuser == agwa_pkg::REQ_RUN) |=> !s_tready)
		else $error("input accepted right after a run request");
	a_lens_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tuser == agwa_pkg::REQ_RUN) |=> (len1_q == '0 && len2_q == '0 && !ovf_q))
		else $error("sequences not cleared by run");
`endif

endmodule
